[rtl/mlfs_pkg.sv]
package mlfs_pkg;

   localparam int BYTE_W       = 8;
   localparam int MAGIC_W      = 32;
   localparam int LEN_W        = 21;
   localparam int ERR_W        = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;

   localparam int HEADER_BYTES_DEF = 16;
   localparam int MAGIC_POS_DEF    = 0;
   localparam int LENGTH_POS_DEF   = 4;

   // command queue between parser and output sequencer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MAGIC_W-1:0] MAGIC_RESET   = '0;
   localparam logic [LEN_W-1:0]   MAX_LEN_RESET = LEN_W'(4096);
   localparam logic [ERR_W-1:0]   ERR_MAX       = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_WORD       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LENGTH = 1'b1;

   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_ABORT,
      CMD_HEADER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [BYTE_W-1:0]       data;
      logic                    last;
      logic [LEN_W-1:0]        length;
      logic [ERR_W-1:0]        errors;
   } cmd_type;

endpackage

[rtl/mlfs_front.sv]
module mlfs_front
   import mlfs_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAGIC_POS    = MAGIC_POS_DEF,
   parameter int LENGTH_POS   = LENGTH_POS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                q_full,
   input  logic                                req_type,
   input  logic [BYTE_W-1:0]                   req_data_byte,
   input  logic [MAGIC_W-1:0]                  magic_word,
   input  logic [LEN_W-1:0]                    max_frame_length,
   output logic                                cmd_push,
   output cmd_type                             cmd,
   output logic [HEADER_BYTES-1:0][BYTE_W-1:0] cmd_window
);

   localparam int FILL_W = $clog2(HEADER_BYTES);

   logic [HEADER_BYTES-1:0][BYTE_W-1:0] window_ff, window_in;
   logic [HEADER_BYTES-1:0][BYTE_W-1:0] cand;
   logic [HEADER_BYTES-1:0][BYTE_W-1:0] shifted;
   logic [FILL_W-1:0]                   fill_ff, fill_in;
   logic                                in_frame_ff, in_frame_in;
   logic [LEN_W-1:0]                    remaining_ff, remaining_in;
   logic [LEN_W-1:0]                    remaining_dec;
   logic [LEN_W-1:0]                    cur_len_ff, cur_len_in;
   logic [ERR_W-1:0]                    err_ff, err_in;
   logic [MAGIC_W-1:0]                  magic_seen;
   logic [MAGIC_W-1:0]                  length_seen;
   logic                                header_ok;
   logic                                accept;

   assign accept = push && !q_full;

   // candidate window with the new byte in place, and its one-byte slide
   always_comb begin
      cand          = window_ff;
      cand[fill_ff] = req_data_byte;
      for (int i = 0; i < HEADER_BYTES - 1; i++) begin
         shifted[i] = cand[i + 1];
      end
      shifted[HEADER_BYTES-1] = '0;
      magic_seen  = '0;
      length_seen = '0;
      for (int k = 0; k < 4; k++) begin
         magic_seen  = {magic_seen[MAGIC_W-BYTE_W-1:0],
                        cand[(MAGIC_POS + k) % HEADER_BYTES]};
         length_seen = {length_seen[MAGIC_W-BYTE_W-1:0],
                        cand[(LENGTH_POS + k) % HEADER_BYTES]};
      end
      header_ok = (magic_seen == magic_word)
               && (length_seen >= MAGIC_W'(HEADER_BYTES))
               && (length_seen <= MAGIC_W'(max_frame_length));
   end

   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - LEN_W'(1) : '0;

   always_comb begin
      window_in    = window_ff;
      fill_in      = fill_ff;
      in_frame_in  = in_frame_ff;
      remaining_in = remaining_ff;
      cur_len_in   = cur_len_ff;
      err_in       = err_ff;
      cmd_push     = 1'b0;
      cmd.kind     = CMD_BYTE;
      cmd.data     = req_data_byte;
      cmd.last     = 1'b0;
      cmd.length   = cur_len_ff;
      cmd.errors   = err_ff;
      cmd_window   = cand;
      if (accept) begin
         if (req_type == REQ_CLEAR) begin
            // report a discarded frame, drop any partial header
            cmd_push     = in_frame_ff;
            cmd.kind     = CMD_ABORT;
            cmd.last     = 1'b1;
            in_frame_in  = 1'b0;
            remaining_in = '0;
            fill_in      = '0;
         end else if (in_frame_ff) begin
            remaining_in = remaining_dec;
            in_frame_in  = (remaining_dec != '0);
            cmd_push     = 1'b1;
            cmd.last     = (remaining_dec == '0);
         end else if (fill_ff != FILL_W'(HEADER_BYTES - 1)) begin
            window_in = cand;
            fill_in   = fill_ff + FILL_W'(1);
         end else if (!header_ok) begin
            window_in = shifted;
            if (err_ff != ERR_MAX) begin
               err_in = err_ff + ERR_W'(1);
            end
         end else begin
            window_in    = cand;
            fill_in      = '0;
            cur_len_in   = length_seen[LEN_W-1:0];
            remaining_in = length_seen[LEN_W-1:0] - LEN_W'(HEADER_BYTES);
            in_frame_in  = (length_seen[LEN_W-1:0] != LEN_W'(HEADER_BYTES));
            cmd_push     = 1'b1;
            cmd.kind     = CMD_HEADER;
            cmd.length   = length_seen[LEN_W-1:0];
            cmd.last     = (length_seen[LEN_W-1:0] == LEN_W'(HEADER_BYTES));
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (reset) begin
         fill_ff      <= '0;
         in_frame_ff  <= 1'b0;
         remaining_ff <= '0;
         cur_len_ff   <= '0;
         err_ff       <= '0;
      end else begin
         fill_ff      <= fill_in;
         in_frame_ff  <= in_frame_in;
         remaining_ff <= remaining_in;
         cur_len_ff   <= cur_len_in;
         err_ff       <= err_in;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (FILL_W+1)'(fill_ff) < (FILL_W+1)'(HEADER_BYTES))
      else $error("header fill count out of range");

   a_frame_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (remaining_ff != '0) && (fill_ff == '0))
      else $error("in frame with no bytes left or a partial header");

endmodule

[rtl/mlfs_queue.sv]
module mlfs_queue
   import mlfs_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  cmd_type                             wr_cmd,
   input  logic [HEADER_BYTES-1:0][BYTE_W-1:0] wr_window,
   output logic                                q_full,
   input  logic                                rd_en,
   output logic                                rd_valid,
   output cmd_type                             rd_cmd,
   output logic [HEADER_BYTES-1:0][BYTE_W-1:0] rd_window
);

   cmd_type                             cmd_mem [QUEUE_DEPTH];
   logic [HEADER_BYTES-1:0][BYTE_W-1:0] win_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]                   count_ff, count_in;

   assign q_full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid  = (count_ff != '0);
   assign rd_cmd    = cmd_mem[rd_ptr_ff];
   assign rd_window = win_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cmd_mem[wr_ptr_ff] <= wr_cmd;
         win_mem[wr_ptr_ff] <= wr_window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !wr_en || rd_en)
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_valid)
      else $error("command queue read while empty");

endmodule

[rtl/mlfs_back.sv]
module mlfs_back
   import mlfs_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  cmd_type                             head,
   input  logic [HEADER_BYTES-1:0][BYTE_W-1:0] head_window,
   output logic                                head_pop,
   input  logic                                pop,
   output logic                                empty,
   output logic [BYTE_W-1:0]                   rsp_frame_byte,
   output logic                                rsp_first_of_frame,
   output logic                                rsp_last_of_frame,
   output logic [LEN_W-1:0]                    rsp_frame_length,
   output logic                                rsp_frame_aborted,
   output logic [ERR_W-1:0]                    rsp_error_total_out
);

   localparam int IDX_W = $clog2(HEADER_BYTES);

   logic              out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              idx_last;
   logic              load;
   logic [BYTE_W-1:0] byte_in;
   logic              first_in;
   logic              last_in;
   logic              aborted_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              first_ff;
   logic              last_ff;
   logic              aborted_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [ERR_W-1:0]  errors_ff;

   // the output word slot is free, or is being taken this cycle
   assign load     = head_valid && (!out_valid_ff || pop);
   assign idx_last = (idx_ff == IDX_W'(HEADER_BYTES - 1));

   always_comb begin
      unique case (head.kind)
         CMD_BYTE: begin
            byte_in    = head.data;
            first_in   = 1'b0;
            last_in    = head.last;
            aborted_in = 1'b0;
         end
         CMD_ABORT: begin
            byte_in    = '0;
            first_in   = 1'b0;
            last_in    = 1'b1;
            aborted_in = 1'b1;
         end
         CMD_HEADER: begin
            byte_in    = head_window[idx_ff];
            first_in   = (idx_ff == '0);
            last_in    = head.last && idx_last;
            aborted_in = 1'b0;
         end
         default: begin
            byte_in    = '0;
            first_in   = 1'b0;
            last_in    = 1'b0;
            aborted_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      head_pop     = load && ((head.kind != CMD_HEADER) || idx_last);
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load && (head.kind == CMD_HEADER)) begin
         idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= byte_in;
         first_ff   <= first_in;
         last_ff    <= last_in;
         aborted_ff <= aborted_in;
         length_ff  <= head.length;
         errors_ff  <= head.errors;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign empty               = !out_valid_ff;
   assign rsp_frame_byte      = byte_ff;
   assign rsp_first_of_frame  = first_ff;
   assign rsp_last_of_frame   = last_ff;
   assign rsp_frame_length    = length_ff;
   assign rsp_frame_aborted   = aborted_ff;
   assign rsp_error_total_out = errors_ff;

   a_burst_on_header: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> head_valid && (head.kind == CMD_HEADER))
      else $error("burst index advanced without a header at the queue head");

   a_burst_holds: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) && !load |=> $stable(idx_ff))
      else $error("burst index moved while the output word was held");

endmodule

[rtl/magic_length_frame_sync.sv]
// A byte that yields a word is written into the command queue when it is accepted;
// the output sequencer then registers that word onto the result ports when its slot frees.
// Throughput: one input byte per cycle; a passing header is replayed as HEADER_BYTES
// words at one word per cycle from the output sequencer while pop takes them, and push
// backs off (full) once the 4-entry command queue between parser and sequencer fills.
// Reset: synchronous, active high; clears parser, queue and output state, sets
// magic_word to 0 and max_frame_length to 4096. No clearing pass is needed.
module magic_length_frame_sync
   import mlfs_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAGIC_POS    = MAGIC_POS_DEF,
   parameter int LENGTH_POS   = LENGTH_POS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_type,
   input  logic [BYTE_W-1:0]      req_data_byte,
   output logic                   empty,
   input  logic                   pop,
   output logic [BYTE_W-1:0]      rsp_frame_byte,
   output logic                   rsp_first_of_frame,
   output logic                   rsp_last_of_frame,
   output logic [LEN_W-1:0]       rsp_frame_length,
   output logic                   rsp_frame_aborted,
   output logic [ERR_W-1:0]       rsp_error_total_out,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [MAGIC_W-1:0]                  magic_ff, magic_in;
   logic [LEN_W-1:0]                    max_len_ff, max_len_in;
   logic                                q_full;
   logic                                cmd_push;
   cmd_type                             cmd;
   logic [HEADER_BYTES-1:0][BYTE_W-1:0] cmd_window;
   logic                                head_valid;
   logic                                head_pop;
   cmd_type                             head;
   logic [HEADER_BYTES-1:0][BYTE_W-1:0] head_window;

   always_comb begin
      magic_in   = magic_ff;
      max_len_in = max_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAGIC_WORD:       magic_in   = csr_write_data[MAGIC_W-1:0];
            CSR_MAX_FRAME_LENGTH: max_len_in = csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= MAGIC_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         magic_ff   <= magic_in;
         max_len_ff <= max_len_in;
      end
   end

   assign full = q_full;

   mlfs_front #(
      .HEADER_BYTES (HEADER_BYTES),
      .MAGIC_POS    (MAGIC_POS),
      .LENGTH_POS   (LENGTH_POS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .q_full           (q_full),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .magic_word       (magic_ff),
      .max_frame_length (max_len_ff),
      .cmd_push         (cmd_push),
      .cmd              (cmd),
      .cmd_window       (cmd_window)
   );

   mlfs_queue #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (cmd_push),
      .wr_cmd    (cmd),
      .wr_window (cmd_window),
      .q_full    (q_full),
      .rd_en     (head_pop),
      .rd_valid  (head_valid),
      .rd_cmd    (head),
      .rd_window (head_window)
   );

   mlfs_back #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head                (head),
      .head_window         (head_window),
      .head_pop            (head_pop),
      .pop                 (pop),
      .empty               (empty),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_first_of_frame  (rsp_first_of_frame),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_frame_aborted   (rsp_frame_aborted),
      .rsp_error_total_out (rsp_error_total_out)
   );

   a_abort_marks: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_frame_aborted |-> rsp_last_of_frame && !rsp_first_of_frame)
      else $error("aborted word without last mark or with first mark");

endmodule
